// File: rtl/core/mdu_pkg.sv
// ----------------------------------------------------------------------------
// mdu_pkg: shared definitions for the multiply/divide unit
// Opcodes, controller states and the command and status structs that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package mdu_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned DivSteps  = DataWidth;
  localparam int unsigned CntWidth  = $clog2(DivSteps);

  typedef enum logic [2:0] {
    OP_MULT  = 3'd0,
    OP_UMULT = 3'd1,
    OP_DIV   = 3'd2,
    OP_DIVU  = 3'd3,
    OP_MFHI  = 3'd4,
    OP_MFLO  = 3'd5,
    OP_MTHI  = 3'd6,
    OP_MTLO  = 3'd7
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // accept a word: capture operands, do moves and reads
    logic mul_write;  // write the product into hi and lo
    logic div_step;   // one restoring division step
    logic div_write;  // apply signs and write quotient and remainder
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;   // the current division step is the final one
  } status_t;

endpackage

// File: rtl/core/mdu_in_if.sv
// ----------------------------------------------------------------------------
// mdu_in_if: input channel of the multiply/divide unit
// Carries one opcode and the two source operands per word.
// ----------------------------------------------------------------------------
interface mdu_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] operand_s;
  logic [31:0] operand_t;

  modport source (output valid, output opcode, output operand_s, output operand_t,
                  input ready);
  modport sink   (input valid, input opcode, input operand_s, input operand_t,
                  output ready);
endinterface

// File: rtl/core/mdu_out_if.sv
// ----------------------------------------------------------------------------
// mdu_out_if: result channel of the multiply/divide unit
// Carries the value read back by mfhi/mflo, zero for other opcodes.
// ----------------------------------------------------------------------------
interface mdu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;

  modport source (output valid, output read_value, input ready);
  modport sink   (input valid, input read_value, output ready);
endinterface

// File: rtl/core/mdu_ctrl.sv
// ----------------------------------------------------------------------------
// mdu_ctrl: controller of the multiply/divide unit
// Sequences multiplies and divides and owns the handshake of both channels.
// ----------------------------------------------------------------------------
module mdu_ctrl
  import mdu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] opcode_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cmd_t       cmd_o,
  input  status_t    status_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept;
  opcode_e opcode;

  assign opcode = opcode_e'(opcode_i);

  // A new word is taken only when idle and the result register can be refilled.
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (opcode)
            OP_MULT, OP_UMULT: state_d = ST_MUL;
            OP_DIV, OP_DIVU:   state_d = ST_DIV;
            OP_MFHI, OP_MFLO,
            OP_MTHI, OP_MTLO:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL: state_d = ST_IDLE;
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands follow directly from the state; load follows the input handshake.
  always_comb begin
    cmd_o.load      = in_accept;
    cmd_o.mul_write = (state_q == ST_MUL);
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.div_write = (state_q == ST_FIN);
  end

  // The result word is produced when the input word is accepted.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_accept) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/mdu_datapath.sv
// ----------------------------------------------------------------------------
// mdu_datapath: hi/lo registers, multiplier and iterative divider
// Executes the commands of the controller on the operands and hi/lo.
// ----------------------------------------------------------------------------
module mdu_datapath
  import mdu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic [2:0]           opcode_i,
  input  logic [DataWidth-1:0] operand_s_i,
  input  logic [DataWidth-1:0] operand_t_i,
  output status_t              status_o,
  output logic [DataWidth-1:0] read_value_o
);

  opcode_e opcode;

  logic [DataWidth-1:0] hi_q, lo_q;
  logic [DataWidth-1:0] read_value_q;

  // Multiplier operands, extended by one bit so one signed multiply serves both.
  logic signed [DataWidth:0]     mul_a_q, mul_b_q;
  logic signed [2*DataWidth+1:0] product;

  // Divider: quotient shifts in as the dividend shifts out of quo_q.
  logic [DataWidth-1:0] quo_q, dvsr_q, rem_q;
  logic [CntWidth-1:0]  cnt_q;
  logic                 neg_quo_q, neg_rem_q;
  logic                 ext_s, ext_t, neg_s, neg_t, is_signed;
  logic [DataWidth:0]   trial;
  logic [DataWidth-1:0] shifted;

  assign opcode = opcode_e'(opcode_i);

  // Operand signs: only the signed opcodes look at the top bits.
  assign is_signed = (opcode == OP_MULT) || (opcode == OP_DIV);
  assign ext_s     = is_signed && operand_s_i[DataWidth-1];
  assign ext_t     = is_signed && operand_t_i[DataWidth-1];
  assign neg_s     = ext_s;
  assign neg_t     = ext_t;

  assign product = mul_a_q * mul_b_q;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign shifted = {rem_q[DataWidth-2:0], quo_q[DataWidth-1]};
  assign trial   = {rem_q, quo_q[DataWidth-1]} - {1'b0, dvsr_q};

  assign status_o.div_last = (cnt_q == CntWidth'(DivSteps - 1));
  assign read_value_o      = read_value_q;

  // Operand capture and division iteration.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mul_a_q   <= {ext_s, operand_s_i};
      mul_b_q   <= {ext_t, operand_t_i};
      quo_q     <= neg_s ? (DataWidth'(0) - operand_s_i) : operand_s_i;
      dvsr_q    <= neg_t ? (DataWidth'(0) - operand_t_i) : operand_t_i;
      rem_q     <= '0;
      neg_quo_q <= neg_s ^ neg_t;
      neg_rem_q <= neg_s;
    end else if (cmd_i.div_step) begin
      if (!trial[DataWidth]) begin
        rem_q <= trial[DataWidth-1:0];
        quo_q <= {quo_q[DataWidth-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[DataWidth-2:0], 1'b0};
      end
    end
  end

  // Step counter of the divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CntWidth'(1);
    end
  end

  // The hi and lo registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= '0;
      lo_q <= '0;
    end else if (cmd_i.load && (opcode == OP_MTHI)) begin
      hi_q <= operand_s_i;
    end else if (cmd_i.load && (opcode == OP_MTLO)) begin
      lo_q <= operand_s_i;
    end else if (cmd_i.mul_write) begin
      hi_q <= product[2*DataWidth-1:DataWidth];
      lo_q <= product[DataWidth-1:0];
    end else if (cmd_i.div_write) begin
      hi_q <= neg_rem_q ? (DataWidth'(0) - rem_q) : rem_q;
      lo_q <= neg_quo_q ? (DataWidth'(0) - quo_q) : quo_q;
    end
  end

  // Result word: the read value for moves from hi/lo, zero otherwise.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      unique case (opcode)
        OP_MFHI: read_value_q <= hi_q;
        OP_MFLO: read_value_q <= lo_q;
        OP_MULT, OP_UMULT, OP_DIV, OP_DIVU,
        OP_MTHI, OP_MTLO: read_value_q <= '0;
      endcase
    end
  end

endmodule

// File: rtl/core/mips_multiply_divide_unit.sv
// ----------------------------------------------------------------------------
// mips_multiply_divide_unit: multiply/divide unit with hi/lo registers
// Top level joining the controller and the datapath to the two channels.
// ----------------------------------------------------------------------------
// Every accepted word yields one result word, loaded into the result register
// in the cycle of acceptance. A new word is taken only when the unit is idle
// and the result register is empty or is being read in that same cycle, so a
// waiting result holds off the input. mfhi, mflo, mthi and mtlo finish in the
// cycle of acceptance. mult and multu then occupy the unit in ST_MUL, where the
// 33 by 33 bit multiplier writes hi and lo. div and divu occupy it for 32
// restoring radix-2 steps through one subtractor in ST_DIV, then restore signs
// and write hi and lo in ST_FIN. Division by zero and the minimum integer over
// minus one take the same steps as any other divide.
module mips_multiply_divide_unit
  import mdu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  mdu_in_if.sink    in_i,
  mdu_out_if.source out_o
);

  cmd_t    cmd;
  status_t status;

  mdu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .opcode_i    (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  mdu_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .opcode_i     (in_i.opcode),
    .operand_s_i  (in_i.operand_s),
    .operand_t_i  (in_i.operand_t),
    .status_o     (status),
    .read_value_o (out_o.read_value)
  );

  // No word is taken while a division is iterating.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !in_i.ready)
    else $error("input ready during a division step");

  // An accepted word always leaves a result word pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> out_o.valid)
    else $error("accepted word produced no result");

  // The final division step is followed by the write of hi and lo.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_step && status.div_last) |=> cmd.div_write)
    else $error("division finished without writing hi and lo");

endmodule

// File: tb/mips_multiply_divide_unit_tb.sv
// ----------------------------------------------------------------------------
// mips_multiply_divide_unit_tb: self-checking bench for the multiply/divide unit
// Sends a directed set of words covering the operand extremes and the division
// special cases, then about a thousand random words. A predictor keeps its own
// hi/lo pair and works out every read value as each word is accepted. A monitor
// compares each result word with the oldest prediction. Both channels idle at
// random, with calm stretches in between.
// ----------------------------------------------------------------------------
module mips_multiply_divide_unit_tb;
  import mdu_pkg::*;

  localparam int unsigned RandomWords = 1000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 600000;

  typedef struct {
    opcode_e     opcode;
    logic [31:0] operand_s;
    logic [31:0] operand_t;
  } mdu_word_t;

  logic clk_i;
  logic rst_ni;

  mdu_in_if  in_if ();
  mdu_out_if out_if ();

  mips_multiply_divide_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Words waiting to be sent and read values waiting to come back.
  mdu_word_t   words_to_send[$];
  logic [31:0] read_values_due[$];

  // The predictor's copy of the hi/lo pair.
  logic [31:0] model_hi;
  logic [31:0] model_lo;

  int unsigned error_count;
  int unsigned cycle_count;

  // Sender and receiver pacing.
  int unsigned send_gap_left;
  int unsigned send_calm_words;
  int unsigned recv_stall_left;
  int unsigned recv_calm_cycles;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Reset and known values on every input from time zero.
  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.opcode       = OP_MFHI;
    in_if.operand_s    = '0;
    in_if.operand_t    = '0;
    out_if.ready       = 1'b0;
    // The predicted hi/lo pair starts from the reset value of the unit.
    model_hi           = '0;
    model_lo           = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Updates the predicted hi/lo pair for one word and returns its read value.
  function automatic logic [31:0] predict_read_value(mdu_word_t w);
    logic [63:0]        product;
    logic signed [31:0] dividend;
    logic signed [31:0] divisor;
    logic [31:0]        value;
    value = '0;
    case (w.opcode)
      OP_MULT: begin
        product  = {{32{w.operand_s[31]}}, w.operand_s} *
                   {{32{w.operand_t[31]}}, w.operand_t};
        model_lo = product[31:0];
        model_hi = product[63:32];
      end
      OP_UMULT: begin
        product  = {32'd0, w.operand_s} * {32'd0, w.operand_t};
        model_lo = product[31:0];
        model_hi = product[63:32];
      end
      OP_DIV: begin
        dividend = w.operand_s;
        divisor  = w.operand_t;
        if (w.operand_s == 32'h8000_0000 && w.operand_t == 32'hffff_ffff) begin
          // The one quotient that does not fit wraps to the minimum integer.
          model_lo = 32'h8000_0000;
          model_hi = '0;
        end else if (w.operand_t == '0) begin
          model_lo = w.operand_s[31] ? 32'h0000_0001 : 32'hffff_ffff;
          model_hi = w.operand_s;
        end else begin
          // Signed operators truncate toward zero; the remainder follows the dividend.
          model_lo = dividend / divisor;
          model_hi = dividend % divisor;
        end
      end
      OP_DIVU: begin
        if (w.operand_t == '0) begin
          model_lo = 32'hffff_ffff;
          model_hi = w.operand_s;
        end else begin
          model_lo = w.operand_s / w.operand_t;
          model_hi = w.operand_s % w.operand_t;
        end
      end
      OP_MFHI: value = model_hi;
      OP_MFLO: value = model_lo;
      OP_MTHI: model_hi = w.operand_s;
      OP_MTLO: model_lo = w.operand_s;
      default: value = '0;
    endcase
    return value;
  endfunction

  // Idle length: mostly none, sometimes a few cycles, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Operands lean toward the edges of the range and toward small magnitudes.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h0000_0000;
          1:       return 32'h0000_0001;
          2:       return 32'hffff_ffff;
          3:       return 32'h8000_0000;
          default: return 32'h7fff_ffff;
        endcase
      end
      1:       return $urandom_range(0, 15);
      2:       return -$urandom_range(1, 15);
      3:       return $urandom_range(0, 32'hffff);
      default: return $urandom;
    endcase
  endfunction

  function automatic opcode_e pick_opcode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 13) return OP_MULT;
    if (r < 25) return OP_UMULT;
    if (r < 40) return OP_DIV;
    if (r < 52) return OP_DIVU;
    if (r < 69) return OP_MFHI;
    if (r < 86) return OP_MFLO;
    if (r < 93) return OP_MTHI;
    return OP_MTLO;
  endfunction

  task automatic queue_word(opcode_e op, logic [31:0] s, logic [31:0] t);
    mdu_word_t w;
    w.opcode    = op;
    w.operand_s = s;
    w.operand_t = t;
    words_to_send.push_back(w);
  endtask

  // Stimulus and end of run.
  initial begin
    error_count = 0;

    // Hi and lo straight out of reset.
    queue_word(OP_MFHI, 32'hffff_ffff, 32'hffff_ffff);
    queue_word(OP_MFLO, 32'h0000_0000, 32'h0000_0000);
    // Moves with the widest and narrowest values.
    queue_word(OP_MTHI, 32'hffff_ffff, 32'h0000_0000);
    queue_word(OP_MTLO, 32'h0000_0000, 32'hffff_ffff);
    queue_word(OP_MFHI, 32'h0000_0000, 32'h0000_0000);
    queue_word(OP_MFLO, 32'hffff_ffff, 32'hffff_ffff);
    // Products of the extremes, signed and unsigned.
    queue_word(OP_MULT, 32'h8000_0000, 32'h8000_0000);
    queue_word(OP_MFHI, 32'h0, 32'h0);
    queue_word(OP_MFLO, 32'h0, 32'h0);
    queue_word(OP_UMULT, 32'hffff_ffff, 32'hffff_ffff);
    queue_word(OP_MFHI, 32'h0, 32'h0);
    queue_word(OP_MFLO, 32'h0, 32'h0);
    // Minimum integer over minus one.
    queue_word(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    queue_word(OP_MFLO, 32'h0, 32'h0);
    queue_word(OP_MFHI, 32'h0, 32'h0);
    // Signed division by zero, negative and zero dividends.
    queue_word(OP_DIV, 32'h8000_0005, 32'h0000_0000);
    queue_word(OP_MFLO, 32'h0, 32'h0);
    queue_word(OP_MFHI, 32'h0, 32'h0);
    queue_word(OP_DIV, 32'h0000_0000, 32'h0000_0000);
    queue_word(OP_MFLO, 32'h0, 32'h0);
    // Unsigned division by zero.
    queue_word(OP_DIVU, 32'h1234_5678, 32'h0000_0000);
    queue_word(OP_MFLO, 32'h0, 32'h0);
    queue_word(OP_MFHI, 32'h0, 32'h0);
    // Remainder sign follows the dividend, then a quotient with a negative divisor.
    queue_word(OP_DIV, 32'hffff_fff9, 32'h0000_0002);
    queue_word(OP_MFHI, 32'h0, 32'h0);
    queue_word(OP_DIV, 32'h0000_0007, 32'hffff_fffe);
    queue_word(OP_MFLO, 32'h0, 32'h0);

    for (int unsigned i = 0; i < RandomWords; i++) begin
      queue_word(pick_opcode(), pick_operand(), pick_operand());
    end

    // Wait for the last word to go out and its result to come back.
    while (words_to_send.size() != 0 || in_if.valid || read_values_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Driver: presents queued words, predicting each one as it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    mdu_word_t w;
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      send_gap_left   = 0;
      send_calm_words = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        w.opcode    = opcode_e'(in_if.opcode);
        w.operand_s = in_if.operand_s;
        w.operand_t = in_if.operand_t;
        read_values_due.push_back(predict_read_value(w));
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap_left > 0) begin
          in_if.valid <= 1'b0;
          send_gap_left--;
        end else if (words_to_send.size() != 0) begin
          w = words_to_send.pop_front();
          in_if.valid     <= 1'b1;
          in_if.opcode    <= w.opcode;
          in_if.operand_s <= w.operand_s;
          in_if.operand_t <= w.operand_t;
          // Pick the gap after this word; calm stretches send back to back.
          if (send_calm_words > 0) begin
            send_calm_words--;
            send_gap_left = 0;
          end else if ($urandom_range(0, 99) < 5) begin
            send_calm_words = $urandom_range(10, 40);
            send_gap_left   = 0;
          end else begin
            send_gap_left = idle_length();
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls at random and checks each accepted result word.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] due;
    if (!rst_ni) begin
      out_if.ready     <= 1'b0;
      recv_stall_left  = 0;
      recv_calm_cycles = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (read_values_due.size() == 0) begin
          $error("read_value: unexpected result word 0x%08h", out_if.read_value);
          error_count++;
        end else begin
          due = read_values_due.pop_front();
          if (out_if.read_value !== due) begin
            $error("read_value: expected 0x%08h, got 0x%08h", due, out_if.read_value);
            error_count++;
          end
        end
      end
      if (recv_stall_left > 0) begin
        out_if.ready <= 1'b0;
        recv_stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (recv_calm_cycles > 0) begin
          recv_calm_cycles--;
        end else if ($urandom_range(0, 99) < 2) begin
          recv_calm_cycles = $urandom_range(50, 300);
        end else begin
          recv_stall_left = idle_length();
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
